[src/xsks_pkg.sv]
// Shared constants, command codes and interface types of the xorshift64 keystream core.
// Depends on nothing; used by xsks_ctrl, xsks_dp and the top level.
package xsks_pkg;

  localparam logic [63:0] GOLDEN_INIT    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] LCG_MULT       = 64'd6364136223846793005;
  localparam logic [7:0]  EMPTY_KEY_BYTE = 8'hAA;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP     = 4'd0;
  localparam dp_op_t OP_PASS    = 4'd1;
  localparam dp_op_t OP_RESTART = 4'd2;
  localparam dp_op_t OP_START   = 4'd3;
  localparam dp_op_t OP_MIX     = 4'd4;
  localparam dp_op_t OP_MUL0    = 4'd5;
  localparam dp_op_t OP_MUL1    = 4'd6;
  localparam dp_op_t OP_MUL2    = 4'd7;
  localparam dp_op_t OP_ACC     = 4'd8;
  localparam dp_op_t OP_FINISH  = 4'd9;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic state_zero;
    logic last_byte;
    logic out_busy;
  } dp_status_t;

  function automatic logic [63:0] xs_advance(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

endpackage

[src/xsks_ctrl.sv]
// Controller of the xorshift64 keystream core: request acceptance and seeding sequence.
// Depends on xsks_pkg for command and status types.
module xsks_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  xsks_pkg::dp_status_t status,
  output xsks_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIX  = 3'd1;
  localparam logic [2:0] ST_MUL0 = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = xsks_pkg::OP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !status.out_busy;
        if (in_valid && !status.out_busy) begin
          if (in_kind) begin
            cmd.op = xsks_pkg::OP_RESTART;
          end else if (!status.state_zero) begin
            cmd.op = xsks_pkg::OP_PASS;
          end else begin
            cmd.op    = xsks_pkg::OP_START;
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MIX: begin
        cmd.op    = xsks_pkg::OP_MIX;
        state_nxt = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.op    = xsks_pkg::OP_MUL0;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.op    = xsks_pkg::OP_MUL1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op    = xsks_pkg::OP_MUL2;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = xsks_pkg::OP_ACC;
        state_nxt = status.last_byte ? ST_FIN : ST_MIX;
      end
      ST_FIN: begin
        if (!status.out_busy) begin
          cmd.op    = xsks_pkg::OP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/xsks_dp.sv]
// Datapath of the xorshift64 keystream core: key store, shared 32x32 multiplier,
// keystream state and output register. Depends on xsks_pkg.
module xsks_dp #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [xsks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                        cfg_data,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_data_out,
  input  xsks_pkg::dp_cmd_t                  cmd,
  output xsks_pkg::dp_status_t               status
);

  localparam int IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [5:0] MAX_LEN = 6'(MAX_KEY_BYTES);

  logic [7:0]       key_r [MAX_KEY_BYTES];
  logic [5:0]       key_len_r;
  logic [63:0]      ks_r;
  logic [63:0]      acc_r;
  logic [63:0]      x_r;
  logic [63:0]      p0_r;
  logic [31:0]      p1_r;
  logic [31:0]      p2_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       data_r;
  logic             out_valid_r;
  logic [7:0]       out_data_r;

  logic [5:0]       len_clamp;
  logic [CNT_W-1:0] n_eff;
  logic [5:0]       idx_x;
  logic [7:0]       key_byte;
  logic [63:0]      mix_val;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [63:0]      ks_adv;
  logic [63:0]      seed_adv;

  genvar b;
  generate
    for (b = 0; b < MAX_KEY_BYTES; b++) begin : g_key
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          key_r[b] <= 8'd0;
        end else if (cfg_we && cfg_index == xsks_pkg::CFG_IDX_W'(b / 8)) begin
          key_r[b] <= cfg_data[8*(b%8) +: 8];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= 6'd0;
    end else if (cfg_we && cfg_index == xsks_pkg::CFG_KEY_LENGTH) begin
      key_len_r <= cfg_data[5:0];
    end
  end

  always_comb begin
    len_clamp = (key_len_r > MAX_LEN) ? MAX_LEN : key_len_r;
    n_eff     = (len_clamp == 6'd0) ? CNT_W'(1) : CNT_W'(len_clamp);
    idx_x     = 6'(idx_r);
    key_byte  = (len_clamp == 6'd0) ? xsks_pkg::EMPTY_KEY_BYTE : key_r[idx_r];
    mix_val   = acc_r ^ ({56'd0, key_byte} << {idx_x[2:0], 3'b000});
    case (cmd.op)
      xsks_pkg::OP_MUL1: begin
        mul_a = x_r[63:32];
        mul_b = xsks_pkg::LCG_MULT[31:0];
      end
      xsks_pkg::OP_MUL2: begin
        mul_a = x_r[31:0];
        mul_b = xsks_pkg::LCG_MULT[63:32];
      end
      default: begin
        mul_a = x_r[31:0];
        mul_b = xsks_pkg::LCG_MULT[31:0];
      end
    endcase
    mul_p    = 64'(mul_a) * 64'(mul_b);
    ks_adv   = xsks_pkg::xs_advance(ks_r);
    seed_adv = xsks_pkg::xs_advance(acc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r        <= 64'd0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        xsks_pkg::OP_PASS: begin
          ks_r        <= ks_adv;
          out_data_r  <= in_data_byte ^ ks_adv[7:0];
          out_valid_r <= 1'b1;
        end
        xsks_pkg::OP_RESTART: begin
          ks_r <= 64'd0;
        end
        xsks_pkg::OP_START: begin
          acc_r  <= xsks_pkg::GOLDEN_INIT;
          idx_r  <= '0;
          data_r <= in_data_byte;
        end
        xsks_pkg::OP_MIX: begin
          x_r <= mix_val;
        end
        xsks_pkg::OP_MUL0: begin
          p0_r <= mul_p;
        end
        xsks_pkg::OP_MUL1: begin
          p1_r <= mul_p[31:0];
        end
        xsks_pkg::OP_MUL2: begin
          p2_r <= mul_p[31:0];
        end
        xsks_pkg::OP_ACC: begin
          acc_r <= p0_r + {p1_r + p2_r, 32'd0};
          idx_r <= idx_r + IDX_W'(1);
        end
        xsks_pkg::OP_FINISH: begin
          ks_r        <= seed_adv;
          out_data_r  <= data_r ^ seed_adv[7:0];
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.state_zero = (ks_r == 64'd0);
  assign status.last_byte  = (CNT_W'(idx_r) == n_eff - CNT_W'(1));
  assign status.out_busy   = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_data_out      = out_data_r;

endmodule

[src/xorshift64_keystream_xor_core.sv]
// Top level of the xorshift64 keystream XOR core: controller plus datapath.
// Depends on xsks_pkg, xsks_ctrl and xsks_dp.
//
// Each data request is XORed with the low byte of a xorshift64 state that advances once
// per byte; a restart request clears the state and gives no result. While the state is
// seeded, bytes can follow every cycle unless the output stalls, with an output register
// between the two sides. When the state is zero the next data byte first seeds it: each LCG
// step runs through one shared 32x32 multiplier as three partial products, in states MIX,
// MUL0, MUL1, MUL2 and ACC per key byte (an empty key counts as one), then FIN, before that
// byte's result appears. Key registers take effect at the next seeding.
module xorshift64_keystream_xor_core #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_data_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [xsks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  xsks_pkg::dp_cmd_t    cmd;
  xsks_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  xsks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .status   (status),
    .cmd      (cmd)
  );

  xsks_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[test/tb_top.sv]
// Self-checking testbench for xorshift64_keystream_xor_core: directed and random byte
// requests with random backpressure, checked against a keystream tracker kept in a class.
// Depends on xsks_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import xsks_pkg::*;

  localparam int  KEY_BYTES_MAX = 32;
  localparam int  SETTLE_CYCLES = 200;
  localparam int  HOLD_CYCLES   = 90;
  localparam bit  KIND_DATA     = 1'b0;
  localparam bit  KIND_RESTART  = 1'b1;

  class keystream_tracker;
    logic [63:0] key_words [4];
    logic [5:0]  key_len;
    logic [63:0] ks_state;
    logic [7:0]  expected_bytes [$];
    int          mismatches;

    function void clear();
      foreach (key_words[i]) key_words[i] = '0;
      key_len = '0;
      ks_state = '0;
      expected_bytes.delete();
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        CFG_KEY_WORD_0: key_words[0] = val;
        CFG_KEY_WORD_1: key_words[1] = val;
        CFG_KEY_WORD_2: key_words[2] = val;
        CFG_KEY_WORD_3: key_words[3] = val;
        CFG_KEY_LENGTH: key_len = val[5:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] seed_value();
      logic [63:0] s;
      int          n;
      logic [7:0]  kb;
      s = GOLDEN_INIT;
      n = (key_len > KEY_BYTES_MAX) ? KEY_BYTES_MAX : key_len;
      if (n == 0) begin
        s = s ^ {56'd0, EMPTY_KEY_BYTE};
        s = s * LCG_MULT;
      end else begin
        for (int i = 0; i < n; i++) begin
          kb = key_words[i / 8][(i % 8) * 8 +: 8];
          s = s ^ ({56'd0, kb} << ((i % 8) * 8));
          s = s * LCG_MULT;
        end
      end
      return s;
    endfunction

    function void note_request(bit kind, logic [7:0] data);
      logic [63:0] t;
      if (kind == KIND_RESTART) begin
        ks_state = '0;
      end else begin
        if (ks_state == '0) ks_state = seed_value();
        t = ks_state;
        t = t ^ (t << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        ks_state = t;
        expected_bytes.push_back(data ^ t[7:0]);
      end
    endfunction

    task check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%02h", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          report_mismatch($sformatf("data_out 0x%02h, expected 0x%02h", got, want));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_kind;
  logic [7:0]           in_data_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_data_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  keystream_tracker ledger;
  bit               send_calm;
  bit               long_hold;

  xorshift64_keystream_xor_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #8ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(bit kind, logic [7:0] data);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(kind, data);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (ledger.expected_bytes.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_key(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                          logic [63:0] w3, logic [63:0] len_word);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_KEY_WORD_0, w0);
    write_reg(CFG_KEY_WORD_1, w1);
    write_reg(CFG_KEY_WORD_2, w2);
    write_reg(CFG_KEY_WORD_3, w3);
    write_reg(CFG_KEY_LENGTH, len_word);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_length();
    logic [5:0] len;
    case ($urandom_range(0, 9))
      0: len = 6'd0;
      1: len = 6'd32;
      2: len = 6'($urandom_range(33, 63));
      default: len = 6'($urandom_range(1, 12));
    endcase
    return {$urandom, 26'($urandom_range(0, 2 ** 26 - 1)), len};
  endfunction

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++)
      send_item(($urandom_range(0, 11) == 0) ? KIND_RESTART : KIND_DATA,
                8'($urandom_range(0, 255)));
  endtask

  initial begin
    int outcome_gap;
    bit recv_calm;
    out_ready = 1'b0;
    recv_calm = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      outcome_gap = recv_calm ? 0 : $urandom_range(0, 18);
      if (outcome_gap > 0) begin
        out_ready <= 1'b0;
        repeat (outcome_gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.check_byte(out_data_out);
      @(negedge clk);
    end
  end

  initial begin
    ledger = new;
    ledger.clear();
    send_calm    = 1'b0;
    long_hold    = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_DATA;
    in_data_byte = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_KEY_WORD_0;
    cfg_data     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'h55);
    send_item(KIND_RESTART, 8'hFF);
    send_item(KIND_DATA, 8'hAA);
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_RESTART, 8'h3C);
    send_item(KIND_DATA, 8'h01);

    load_key('1, '1, '1, '1, 64'd32);
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_DATA, 8'h7F);

    load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, '0, 64'h8000000000000001, '1);
    write_reg(3'd5, {$urandom, $urandom});
    write_reg(3'd7, '1);
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_DATA, 8'h12);
    send_item(KIND_DATA, 8'h34);

    load_key({$urandom, $urandom}, '0, '0, '0, 64'd1);
    send_item(KIND_DATA, 8'hC3);
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_DATA, 8'h5A);
    send_item(KIND_DATA, 8'hA5);

    for (int phase = 0; phase < 8; phase++) begin
      load_key(pick_word(), pick_word(), pick_word(), pick_word(), pick_length());
      send_calm = ($urandom_range(0, 2) == 0);
      send_item(KIND_RESTART, 8'($urandom_range(0, 255)));
      if (phase == 2) begin
        send_calm = 1'b1;
        long_hold = 1'b1;
      end
      if (phase == 5) begin
        random_burst(35);
        drain_results();
        random_burst(35);
      end else begin
        random_burst(70);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (ledger.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[xorshift64_keystream_xor_core.f]
src/xsks_pkg.sv
src/xsks_ctrl.sv
src/xsks_dp.sv
src/xorshift64_keystream_xor_core.sv
test/tb_top.sv
